// ----- rtl/core/dvpcap_pkg.sv -----
// Shared types and constants for the DVP camera capture block.
package dvpcap_pkg;

  // Bound defaults for the top-level parameters
  localparam int DEF_MAX_ROWS = 480;
  localparam int DEF_MAX_COLS = 640;

  // Field widths
  localparam int ROW_W  = 9;
  localparam int COL_W  = 10;
  localparam int CFG_W  = 10;

  // Register reset values
  localparam logic [ROW_W-1:0] ROWS_RST = 9'd240;
  localparam logic [COL_W-1:0] COLS_RST = 10'd320;

  // Scale-and-round constants for 5- and 6-bit expansion
  localparam logic [9:0] MUL5 = 10'd527;
  localparam logic [4:0] ADD5 = 5'd23;
  localparam logic [8:0] MUL6 = 9'd259;
  localparam logic [5:0] ADD6 = 6'd33;
  localparam int         EXP_SHIFT = 6;

  // Register indexes
  typedef enum logic [0:0] {
    CFG_FRAME_ROWS = 1'b0,
    CFG_FRAME_COLS = 1'b1
  } cfg_idx_t;

  // Capture sequencer phases
  typedef enum logic [3:0] {
    PH_VS_HIGH = 4'b0001,
    PH_VS_LOW  = 4'b0010,
    PH_HS_HIGH = 4'b0100,
    PH_CAPTURE = 4'b1000
  } phase_t;

  typedef struct packed {
    logic       vsync;
    logic       hsync;
    logic       pclk;
    logic [7:0] bus_byte;
  } in_t;

  typedef struct packed {
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [ROW_W-1:0] pixel_row;
    logic [COL_W-1:0] pixel_col;
    logic             frame_done;
  } out_t;

endpackage

// ----- rtl/core/dvpcap_expand.sv -----
// RGB565 byte pair to RGB888 expansion.
module dvpcap_expand (
  input  logic [7:0] first_byte,
  input  logic [7:0] second_byte,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue
);

  logic [4:0]  r5;
  logic [5:0]  g6;
  logic [4:0]  b5;
  logic [13:0] r_sum;
  logic [13:0] g_sum;
  logic [13:0] b_sum;

  assign r5 = first_byte[7:3];
  assign g6 = {first_byte[2:0], second_byte[7:5]};
  assign b5 = second_byte[4:0];

  // Scale at full 14-bit width, add rounding term, drop fraction bits
  assign r_sum = 14'(r5) * 14'(dvpcap_pkg::MUL5) + 14'(dvpcap_pkg::ADD5);
  assign g_sum = 14'(g6) * 14'(dvpcap_pkg::MUL6) + 14'(dvpcap_pkg::ADD6);
  assign b_sum = 14'(b5) * 14'(dvpcap_pkg::MUL5) + 14'(dvpcap_pkg::ADD5);

  assign red   = r_sum[dvpcap_pkg::EXP_SHIFT +: 8];
  assign green = g_sum[dvpcap_pkg::EXP_SHIFT +: 8];
  assign blue  = b_sum[dvpcap_pkg::EXP_SHIFT +: 8];

endmodule

// ----- rtl/core/camera_dvp_capture_rgb565.sv -----
// Top level of the DVP camera capture block: sync tracking, byte pairing, output buffer.
//
//   channel | ports                       | moves
//   --------+-----------------------------+-------------------------------------
//   in      | in_valid/in_ready/in_data   | one pin sample request per cycle while the skid is empty
//   out     | out_valid/out_ready/out_data| one RGB888 pixel request per pair
//   cfg     | cfg_we/cfg_idx/cfg_wdata    | frame_rows, frame_cols writes
//
// The phase sequencer and pixel counters update at the edge that accepts a pin
// sample request, and the expanded pixel is registered at the edge that accepts
// its completing sample, in the output register or, if that is stalled, in the skid.
// Reset is synchronous, active low, and clears sequencer, counters, held byte and valid flags.
// A stalled output holds in a two-entry buffer (output register plus skid);
// in_ready drops only while the skid entry is occupied.
module camera_dvp_capture_rgb565 #(
  parameter int MAX_ROWS = dvpcap_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = dvpcap_pkg::DEF_MAX_COLS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  dvpcap_pkg::in_t                   in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output dvpcap_pkg::out_t                  out_data,
  input  logic                              cfg_we,
  input  dvpcap_pkg::cfg_idx_t              cfg_idx,
  input  logic [dvpcap_pkg::CFG_W-1:0]      cfg_wdata
);

  localparam int RW = dvpcap_pkg::ROW_W;
  localparam int CW = dvpcap_pkg::COL_W;
  // Only selected when the register exceeds the bound, so truncation is safe
  localparam logic [RW-1:0] ROWS_CAP = RW'(MAX_ROWS);
  localparam logic [CW-1:0] COLS_CAP = CW'(MAX_COLS);

  // Configuration registers
  logic [RW-1:0] cfg_rows_r;
  logic [CW-1:0] cfg_cols_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_rows_r <= dvpcap_pkg::ROWS_RST;
      cfg_cols_r <= dvpcap_pkg::COLS_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        dvpcap_pkg::CFG_FRAME_ROWS: cfg_rows_r <= cfg_wdata[RW-1:0];
        dvpcap_pkg::CFG_FRAME_COLS: cfg_cols_r <= cfg_wdata[CW-1:0];
      endcase
    end
  end

  // Effective bounds: zero reads as one, clamp to the maximum
  logic [RW-1:0] rows_eff;
  logic [CW-1:0] cols_eff;

  always_comb begin
    if (cfg_rows_r == '0) begin
      rows_eff = RW'(1);
    end else if (int'(cfg_rows_r) > MAX_ROWS) begin
      rows_eff = ROWS_CAP;
    end else begin
      rows_eff = cfg_rows_r;
    end
    if (cfg_cols_r == '0) begin
      cols_eff = CW'(1);
    end else if (int'(cfg_cols_r) > MAX_COLS) begin
      cols_eff = COLS_CAP;
    end else begin
      cols_eff = cfg_cols_r;
    end
  end

  // Sequencer state
  dvpcap_pkg::phase_t phase_r, phase_nxt;
  logic          seen_high_r, seen_high_nxt;
  logic          second_r, second_nxt;
  logic [7:0]    held_r, held_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;

  logic             in_fire;
  logic             res_v;
  logic             res_done;
  logic [RW:0]      row_inc;
  logic [CW:0]      col_inc;
  dvpcap_pkg::out_t res;
  logic [7:0]       exp_red, exp_green, exp_blue;

  assign in_fire = in_valid && in_ready;
  assign row_inc = {1'b0, row_r} + (RW+1)'(1);
  assign col_inc = {1'b0, col_r} + (CW+1)'(1);

  dvpcap_expand u_expand (
    .first_byte  (held_r),
    .second_byte (in_data.bus_byte),
    .red         (exp_red),
    .green       (exp_green),
    .blue        (exp_blue)
  );

  always_comb begin
    phase_nxt     = phase_r;
    seen_high_nxt = seen_high_r;
    second_nxt    = second_r;
    held_nxt      = held_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    res_v         = 1'b0;
    res_done      = 1'b0;
    if (in_fire) begin
      unique case (phase_r)
        dvpcap_pkg::PH_VS_LOW: begin
          if (!in_data.vsync) phase_nxt = dvpcap_pkg::PH_HS_HIGH;
        end
        dvpcap_pkg::PH_HS_HIGH: begin
          if (in_data.hsync) begin
            phase_nxt     = dvpcap_pkg::PH_CAPTURE;
            seen_high_nxt = 1'b0;
          end
        end
        dvpcap_pkg::PH_CAPTURE: begin
          if (!seen_high_r) begin
            seen_high_nxt = in_data.pclk;
          end else if (!in_data.pclk) begin
            // Falling pclk edge: take a byte
            seen_high_nxt = 1'b0;
            if (!second_r) begin
              held_nxt   = in_data.bus_byte;
              second_nxt = 1'b1;
            end else begin
              second_nxt = 1'b0;
              res_v      = 1'b1;
              col_nxt    = col_inc[CW-1:0];
              if (col_inc >= {1'b0, cols_eff}) begin
                col_nxt = '0;
                row_nxt = row_inc[RW-1:0];
                if (row_inc >= {1'b0, rows_eff}) begin
                  row_nxt   = '0;
                  phase_nxt = dvpcap_pkg::PH_VS_HIGH;
                  res_done  = 1'b1;
                end else begin
                  phase_nxt = dvpcap_pkg::PH_HS_HIGH;
                end
              end
            end
          end
        end
        default: begin
          // Waiting for vsync high; stray codes land here too
          phase_nxt = in_data.vsync ? dvpcap_pkg::PH_VS_LOW : dvpcap_pkg::PH_VS_HIGH;
        end
      endcase
    end
  end

  always_comb begin
    res.red        = exp_red;
    res.green      = exp_green;
    res.blue       = exp_blue;
    res.pixel_row  = row_r;
    res.pixel_col  = col_r;
    res.frame_done = res_done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= dvpcap_pkg::PH_VS_HIGH;
      seen_high_r <= 1'b0;
      second_r    <= 1'b0;
      held_r      <= '0;
      row_r       <= '0;
      col_r       <= '0;
    end else begin
      phase_r     <= phase_nxt;
      seen_high_r <= seen_high_nxt;
      second_r    <= second_nxt;
      held_r      <= held_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
    end
  end

  // Output register plus skid entry
  logic             out_valid_r, out_valid_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  dvpcap_pkg::out_t out_r, out_nxt;
  dvpcap_pkg::out_t skid_r, skid_nxt;
  logic             out_fire;

  assign out_fire  = out_valid_r && out_ready;
  assign in_ready  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      // Input is blocked; drain skid into the output slot
      if (out_fire) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (res_v) begin
      if (!out_valid_r || out_fire) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  // Skid entry only fills behind an occupied output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid with empty output register");

  // A held skid request keeps its payload until it moves forward
  a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_fire) |=> (skid_valid_r && $stable(skid_r)))
    else $error("skid entry changed while stalled");

  // Pixels complete only on the second byte during capture
  a_pixel_on_second: assert property (@(posedge clk) disable iff (!rst_n)
    res_v |-> (second_r && phase_r == dvpcap_pkg::PH_CAPTURE))
    else $error("pixel produced outside second-byte capture");

  // End of frame sends the sequencer back to waiting for vsync
  a_done_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    (res_v && res_done) |=> (phase_r == dvpcap_pkg::PH_VS_HIGH && row_r == '0 && col_r == '0))
    else $error("frame end did not rewind sequencer");

endmodule
